// File: rtl/hnmf_pkg.sv
// shared types and constants for the four-neighbour height mean filter
package hnmf_pkg;

	localparam int HEIGHT_W = 16;
	localparam int MAX_SIDE = 1024;
	localparam int COL_W    = $clog2(MAX_SIDE);
	localparam int GRID_W   = COL_W + 1;
	localparam int SUM_W    = HEIGHT_W + 2;

	localparam logic [GRID_W-1:0] SIDE_MIN   = GRID_W'(2);
	localparam logic [GRID_W-1:0] SIDE_MAX   = GRID_W'(MAX_SIDE);
	localparam logic [GRID_W-1:0] SIDE_RESET = GRID_W'(256);

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_FLUSH  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		DIV_2,
		DIV_3,
		DIV_4
	} divisor_t;

	typedef struct packed {
		cmd_t                       command;
		logic signed [HEIGHT_W-1:0] height;
	} in_beat_t;

	typedef struct packed {
		logic signed [HEIGHT_W-1:0] smoothed;
		logic [COL_W-1:0]           out_row;
		logic [COL_W-1:0]           out_col;
		logic                       frame_last;
	} out_beat_t;

	typedef struct packed {
		logic signed [HEIGHT_W-1:0] prev;
		logic signed [HEIGHT_W-1:0] older;
	} line_entry_t;

	typedef struct packed {
		logic             wr_en;
		logic [COL_W-1:0] wr_addr;
		logic             rd_en;
		logic [COL_W-1:0] rd_addr;
	} line_ctrl_t;

endpackage

// File: rtl/heightmap_neighbour_mean_filter_unit.sv
// top level of the four-neighbour height mean filter
// an accepted beat passes three registered stages to its result; results trail input by one row
// throughput: one beat per cycle while sample_stall is low, limited by one line store write and one read per beat
// reset: counters cleared, grid size 256, pipeline empty; line store contents not cleared
// sample_stall rises only while all three stages are full and the result is stalled
module heightmap_neighbour_mean_filter_unit
	import hnmf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  in_beat_t          sample,
	output logic              result_valid,
	input  logic              result_stall,
	output out_beat_t         result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [GRID_W-1:0] cfg_data
);

	typedef struct packed {
		logic [COL_W-1:0]           row;
		logic [COL_W-1:0]           col;
		logic                       last;
		logic                       has_up;
		logic                       has_down;
		logic                       has_left;
		logic                       has_right;
		logic signed [HEIGHT_W-1:0] up;
		logic signed [HEIGHT_W-1:0] down;
		logic signed [HEIGHT_W-1:0] left;
	} s1_t;

	typedef struct packed {
		logic [COL_W-1:0]        row;
		logic [COL_W-1:0]        col;
		logic                    last;
		logic signed [SUM_W-1:0] sum;
		divisor_t                div;
	} s2_t;

	logic [GRID_W-1:0]          side_q;
	logic [GRID_W-1:0]          row_q;
	logic [COL_W-1:0]           col_q;
	logic signed [HEIGHT_W-1:0] left_q;

	logic        v_s1, v_s2, v_s3;
	s1_t         p_s1;
	s2_t         p_s2;
	out_beat_t   p_s3;

	logic        out_free, s2_free, s1_free;
	logic        accept, is_flush, row_full, active, emits, col_last;
	logic [GRID_W-1:0] row_m1;
	logic [COL_W-1:0]  col_inc;
	logic [GRID_W-1:0] side_new;

	line_ctrl_t  mem_ctrl;
	line_entry_t mem_wr, mem_rd;

	s1_t               s1_next;
	logic signed [SUM_W-1:0] sum_c;
	divisor_t          div_c;
	logic [2:0]        tally;
	logic signed [HEIGHT_W-1:0] mean;

	// handshake
	assign out_free     = !v_s3 || !result_stall;
	assign s2_free      = !v_s2 || out_free;
	assign s1_free      = !v_s1 || s2_free;
	assign sample_stall = !s1_free;
	assign cfg_ready    = 1'b1;
	assign accept       = sample_valid && !sample_stall;

	// beat decode
	assign is_flush = (sample.command == CMD_FLUSH);
	assign row_full = (row_q == side_q);
	assign active   = accept && (is_flush ? row_full : !row_full);
	assign emits    = active && (is_flush || (row_q != '0));
	assign col_inc  = col_q + COL_W'(1);
	assign col_last = (({1'b0, col_q} + GRID_W'(1)) == side_q);
	assign row_m1   = row_q - GRID_W'(1);

	always_comb begin
		if (cfg_data < SIDE_MIN) begin
			side_new = SIDE_MIN;
		end else if (cfg_data > SIDE_MAX) begin
			side_new = SIDE_MAX;
		end else begin
			side_new = cfg_data;
		end
	end

	// line store: write current column, prefetch next column
	assign mem_ctrl.wr_en   = active;
	assign mem_ctrl.wr_addr = col_q;
	assign mem_ctrl.rd_en   = active;
	assign mem_ctrl.rd_addr = col_last ? '0 : col_inc;
	assign mem_wr.prev      = is_flush ? mem_rd.prev : sample.height;
	assign mem_wr.older     = mem_rd.prev;

	hnmf_line_mem u_line_mem (
		.clk     (clk),
		.ctrl    (mem_ctrl),
		.wr_data (mem_wr),
		.rd_data (mem_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_RESET;
			row_q  <= '0;
			col_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			side_q <= side_new;
			row_q  <= '0;
			col_q  <= '0;
		end else if (active) begin
			col_q <= col_last ? '0 : col_inc;
			if (col_last) begin
				row_q <= is_flush ? '0 : row_q + GRID_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (active) begin
			left_q <= mem_rd.prev;
		end
	end

	// stage 1 load
	always_comb begin
		s1_next.row       = row_m1[COL_W-1:0];
		s1_next.col       = col_q;
		s1_next.last      = is_flush && col_last;
		s1_next.has_up    = (row_q != GRID_W'(1));
		s1_next.has_down  = !is_flush;
		s1_next.has_left  = (col_q != '0);
		s1_next.has_right = !col_last;
		s1_next.up        = mem_rd.older;
		s1_next.down      = sample.height;
		s1_next.left      = left_q;
	end

	// stage 1 neighbour sum, right neighbour from the prefetched entry
	always_comb begin
		sum_c = (p_s1.has_up ? SUM_W'(p_s1.up) : '0)
			+ (p_s1.has_down ? SUM_W'(p_s1.down) : '0)
			+ (p_s1.has_left ? SUM_W'(p_s1.left) : '0)
			+ (p_s1.has_right ? SUM_W'(mem_rd.prev) : '0);
		tally = {2'b00, p_s1.has_up} + {2'b00, p_s1.has_down}
			+ {2'b00, p_s1.has_left} + {2'b00, p_s1.has_right};
		unique case (tally)
			3'd2:    div_c = DIV_2;
			3'd3:    div_c = DIV_3;
			default: div_c = DIV_4;
		endcase
	end

	hnmf_round_div u_round_div (
		.sum  (p_s2.sum),
		.div  (p_s2.div),
		.mean (mean)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (s1_free) begin
				v_s1 <= emits;
			end
			if (s2_free) begin
				v_s2 <= v_s1;
			end
			if (out_free) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free) begin
			p_s1 <= s1_next;
		end
		if (s2_free) begin
			p_s2.row  <= p_s1.row;
			p_s2.col  <= p_s1.col;
			p_s2.last <= p_s1.last;
			p_s2.sum  <= sum_c;
			p_s2.div  <= div_c;
		end
		if (out_free) begin
			p_s3.smoothed   <= mean;
			p_s3.out_row    <= p_s2.row;
			p_s3.out_col    <= p_s2.col;
			p_s3.frame_last <= p_s2.last;
		end
	end

	assign result_valid = v_s3;
	assign result       = p_s3;

endmodule

// File: rtl/hnmf_line_mem.sv
// line store holding the previous and older row per column, registered read
module hnmf_line_mem
	import hnmf_pkg::*;
(
	input  logic        clk,
	input  line_ctrl_t  ctrl,
	input  line_entry_t wr_data,
	output line_entry_t rd_data
);

	line_entry_t mem [MAX_SIDE];
	line_entry_t rd_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[ctrl.wr_addr] <= wr_data;
		end
		if (ctrl.rd_en) begin
			rd_q <= mem[ctrl.rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// File: rtl/hnmf_round_div.sv
// divide a neighbour sum by 2, 3 or 4, rounding to nearest, ties away from zero
module hnmf_round_div
	import hnmf_pkg::*;
(
	input  logic signed [SUM_W-1:0]    sum,
	input  divisor_t                   div,
	output logic signed [HEIGHT_W-1:0] mean
);

	localparam int Y_W        = SUM_W + 1;
	localparam int DIV3_SHIFT = Y_W + 2;
	localparam int PROD_W     = Y_W + DIV3_SHIFT;
	localparam longint unsigned DIV3_MUL_L =
		((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3;
	localparam logic [DIV3_SHIFT-1:0] DIV3_MUL = DIV3_SHIFT'(DIV3_MUL_L);

	logic             neg;
	logic [SUM_W-1:0] mag;
	logic [Y_W-1:0]   y;
	logic [PROD_W-1:0] prod;
	logic [Y_W-1:0]   q;
	logic [Y_W-1:0]   q_signed;

	// floor((mag + 1) / 3) through a reciprocal multiply
	assign neg  = sum[SUM_W-1];
	assign mag  = neg ? (~$unsigned(sum) + SUM_W'(1)) : $unsigned(sum);
	assign y    = {1'b0, mag} + ((div == DIV_4) ? Y_W'(2) : Y_W'(1));
	assign prod = PROD_W'(y) * PROD_W'(DIV3_MUL);

	always_comb begin
		unique case (div)
			DIV_2:   q = y >> 1;
			DIV_3:   q = prod[DIV3_SHIFT +: Y_W];
			DIV_4:   q = y >> 2;
			default: q = y >> 2;
		endcase
	end

	assign q_signed = neg ? (~q + Y_W'(1)) : q;
	assign mean     = $signed(q_signed[HEIGHT_W-1:0]);

endmodule

// File: rtl/hnmf_checker.sv
// port-level checks for the four-neighbour height mean filter, bound to the top level
module hnmf_checker
	import hnmf_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      sample_stall,
	input logic      result_valid,
	input logic      result_stall,
	input out_beat_t result
);

	// stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(result)))
		else $error("result beat changed while stalled");

	// input backpressure only comes from a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (result_valid && result_stall))
		else $error("input stalled without a blocked result");

	// frame end is on the diagonal corner
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.frame_last) |-> (result.out_row == result.out_col))
		else $error("frame end not at the last corner");

	// next frame starts at the origin
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && result.frame_last) |=>
		(!result_valid || (result.out_row == '0 && result.out_col == '0)))
		else $error("result after frame end not at origin");

endmodule

bind heightmap_neighbour_mean_filter_unit hnmf_checker u_hnmf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_stall (sample_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

// File: tb/testbench.sv
// self-checking testbench for the four-neighbour height mean filter
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import hnmf_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              sample_valid = 1'b0;
	logic              sample_stall;
	in_beat_t          sample = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	out_beat_t         result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [GRID_W-1:0] cfg_data = '0;

	heightmap_neighbour_mean_filter_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	in_beat_t  pending[$];
	out_beat_t mean_q[$];

	logic signed [HEIGHT_W-1:0] line_prev [MAX_SIDE];
	logic signed [HEIGHT_W-1:0] line_older[MAX_SIDE];
	int unsigned side_n = 256;
	int unsigned rows_in = 0;
	int unsigned next_col = 0;

	int errors = 0;
	int beats_in = 0;
	int results_seen = 0;
	int cfg_writes = 0;
	int stim_count = 0;
	int drv_wait = 0;
	int mon_wait = 0;
	bit calm = 1'b0;
	out_beat_t want;

	task automatic flag_mismatch(string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		errors++;
	endtask

	function automatic out_beat_t neighbour_mean(int unsigned orow, int unsigned c, bit has_down,
			logic signed [HEIGHT_W-1:0] down);
		int sum;
		int cnt;
		int mag;
		int q;
		out_beat_t r;
		sum = 0;
		cnt = 0;
		if (orow > 0) begin
			sum = sum + line_older[c];
			cnt++;
		end
		if (has_down) begin
			sum = sum + down;
			cnt++;
		end
		if (c > 0) begin
			sum = sum + line_older[c-1];
			cnt++;
		end
		if (c + 1 < side_n) begin
			sum = sum + line_prev[c+1];
			cnt++;
		end
		mag = (sum < 0) ? -sum : sum;
		q = (2 * mag + cnt) / (2 * cnt);
		r.smoothed = HEIGHT_W'((sum < 0) ? -q : q);
		r.out_row = COL_W'(orow);
		r.out_col = COL_W'(c);
		r.frame_last = (orow + 1 == side_n) && (c + 1 == side_n);
		return r;
	endfunction

	function automatic void advance_filter(in_beat_t b);
		int unsigned c;
		c = next_col;
		if (b.command == CMD_SAMPLE) begin
			if (rows_in >= side_n)
				return;
			if (rows_in > 0)
				mean_q.push_back(neighbour_mean(rows_in - 1, c, 1'b1, b.height));
			line_older[c] = line_prev[c];
			line_prev[c] = b.height;
			if (c + 1 == side_n) begin
				next_col = 0;
				rows_in++;
			end else begin
				next_col = c + 1;
			end
		end else begin
			if (rows_in != side_n)
				return;
			mean_q.push_back(neighbour_mean(side_n - 1, c, 1'b0, '0));
			line_older[c] = line_prev[c];
			if (c + 1 == side_n) begin
				next_col = 0;
				rows_in = 0;
			end else begin
				next_col = c + 1;
			end
		end
	endfunction

	// input driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && !sample_stall) begin
				advance_filter(sample);
				beats_in++;
			end
			if (!sample_valid || !sample_stall) begin
				if (drv_wait > 0) begin
					drv_wait--;
					sample_valid <= 1'b0;
				end else if (pending.size() > 0) begin
					sample <= pending.pop_front();
					sample_valid <= 1'b1;
					drv_wait = calm ? 0 : $urandom_range(0, 6);
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				results_seen++;
				if (mean_q.size() == 0) begin
					flag_mismatch("result beat with nothing expected");
				end else begin
					want = mean_q.pop_front();
					if (result.smoothed !== want.smoothed)
						flag_mismatch($sformatf("(%0d,%0d) smoothed %0d, want %0d",
							want.out_row, want.out_col, result.smoothed, want.smoothed));
					if (result.out_row !== want.out_row)
						flag_mismatch($sformatf("(%0d,%0d) out_row %0d",
							want.out_row, want.out_col, result.out_row));
					if (result.out_col !== want.out_col)
						flag_mismatch($sformatf("(%0d,%0d) out_col %0d",
							want.out_row, want.out_col, result.out_col));
					if (result.frame_last !== want.frame_last)
						flag_mismatch($sformatf("(%0d,%0d) frame_last %b, want %b",
							want.out_row, want.out_col, result.frame_last, want.frame_last));
				end
				mon_wait = calm ? 0 : $urandom_range(0, 6);
			end
			if (mon_wait > 0) begin
				mon_wait--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	function automatic logic signed [HEIGHT_W-1:0] pick_height();
		int v;
		case ($urandom_range(0, 9))
			0: v = 32767;
			1: v = -32768;
			2, 3: v = $urandom_range(0, 8) - 4;
			default: v = $urandom;
		endcase
		return HEIGHT_W'(v);
	endfunction

	function automatic void push_item(cmd_t cmd, logic signed [HEIGHT_W-1:0] h, bit counted);
		in_beat_t b;
		b.command = cmd;
		b.height = h;
		pending.push_back(b);
		if (counted)
			stim_count++;
	endfunction

	// rows full rows then tail samples; a full grid gets its flush row
	function automatic void queue_frame(int n, int rows, int tail, bit noisy);
		for (int i = 0; i < rows * n + tail; i++) begin
			if (noisy && $urandom_range(0, 24) == 0)
				push_item(CMD_FLUSH, pick_height(), 1'b0);
			push_item(CMD_SAMPLE, pick_height(), 1'b1);
		end
		if (rows == n) begin
			for (int c = 0; c < n; c++) begin
				if (noisy && $urandom_range(0, 9) == 0)
					push_item(CMD_SAMPLE, pick_height(), 1'b0);
				push_item(CMD_FLUSH, HEIGHT_W'($urandom), 1'b1);
			end
		end
	endfunction

	task automatic settle();
		@(negedge clk);
		while (pending.size() > 0 || sample_valid || mean_q.size() > 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_grid(logic [GRID_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		side_n = (v < SIDE_MIN) ? 2 : (v > SIDE_MAX) ? MAX_SIDE : int'(v);
		rows_in = 0;
		next_col = 0;
		cfg_writes++;
		@(negedge clk);
	endtask

	initial begin
		int n;
		int frames;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset grid size, early flush, then one row and a bit
		push_item(CMD_FLUSH, 16'sh1234, 1'b1);
		queue_frame(256, 1, 2, 1'b0);
		settle();

		write_grid(GRID_W'(2));
		push_item(CMD_FLUSH, 16'sh0000, 1'b1);
		push_item(CMD_SAMPLE, 16'sh7fff, 1'b1);
		push_item(CMD_SAMPLE, 16'sh8000, 1'b1);
		push_item(CMD_SAMPLE, 16'sh8000, 1'b1);
		push_item(CMD_SAMPLE, 16'sh7fff, 1'b1);
		push_item(CMD_SAMPLE, 16'sh5555, 1'b1);
		push_item(CMD_FLUSH, 16'shffff, 1'b1);
		push_item(CMD_FLUSH, 16'shaaaa, 1'b1);
		// odd sums to hit rounding ties on both signs
		push_item(CMD_SAMPLE, 16'sh0001, 1'b1);
		push_item(CMD_SAMPLE, 16'sh0000, 1'b1);
		push_item(CMD_SAMPLE, -16'sh0001, 1'b1);
		push_item(CMD_SAMPLE, 16'sh0002, 1'b1);
		push_item(CMD_FLUSH, 16'sh0000, 1'b1);
		push_item(CMD_FLUSH, 16'sh0000, 1'b1);
		settle();
		write_grid(GRID_W'(0));
		queue_frame(2, 2, 0, 1'b0);
		settle();
		write_grid(GRID_W'(1));
		queue_frame(2, 2, 0, 1'b0);
		settle();

		// largest side, reached by clamping
		write_grid(GRID_W'(2047));
		queue_frame(MAX_SIDE, 1, 2, 1'b0);
		settle();

		while (stim_count < 1650) begin
			case ($urandom_range(0, 19))
				0: n = $urandom_range(9, 12);
				1, 2, 3, 4, 5: n = $urandom_range(5, 8);
				default: n = $urandom_range(2, 4);
			endcase
			calm = ($urandom_range(0, 3) == 0);
			write_grid((n == 2) ? GRID_W'($urandom_range(0, 2)) : GRID_W'(n));
			frames = $urandom_range(1, 2);
			for (int f = 0; f < frames; f++) begin
				if (f == frames - 1 && $urandom_range(0, 6) == 0)
					queue_frame(n, $urandom_range(0, n - 1), $urandom_range(0, n - 1), 1'b1);
				else
					queue_frame(n, n, 0, $urandom_range(0, 4) == 0);
			end
			settle();
		end

		$display("run covered %0d input beats and %0d result beats", beats_in, results_seen);
		$display("across %0d grid size writes, from the smallest side to the largest",
			cfg_writes);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
